// File: design/ucyr_pkg.sv
// Package for the UTF-8 Cyrillic transliterator: job type, queue sizing,
// code point constants and the Cyrillic-to-Latin letter table.
// Depends on nothing; used by the front, queue and back modules.
package ucyr_pkg;

   // Largest number of characters one input byte can give.
   localparam int MAX_CHARS      = 4;
   localparam int COUNT_BITS     = $clog2(MAX_CHARS + 1);
   localparam int INDEX_BITS     = $clog2(MAX_CHARS);

   // Depth of the job queue between the front and back parts.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Byte classification.
   localparam logic [7:0] LEAD_MASK    = 8'hE0;
   localparam logic [7:0] LEAD_PATTERN = 8'hC0;
   localparam logic [7:0] LEAD_BITS    = 8'h1F;
   localparam logic [7:0] TRAIL_BITS   = 8'h3F;

   // Code points.
   localparam logic [10:0] CODE_TABLE_BASE = 11'h410;
   localparam logic [10:0] CODE_TABLE_END  = 11'h450;
   localparam logic [10:0] CODE_YO_UPPER   = 11'h401;
   localparam logic [10:0] CODE_YO_LOWER   = 11'h451;

   localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;
   localparam logic [7:0] CASE_BIT     = 8'h20;

   // One unit of work: the characters to emit, first in element zero.
   typedef struct packed {
      logic [COUNT_BITS-1:0]          count;
      logic [MAX_CHARS-1:0][7:0]      chars;
   } job_type;

   function automatic job_type mk_job(input logic [COUNT_BITS-1:0] n,
                                      input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [7:0] c3);
      job_type j;
      j.count = n;
      j.chars = {c3, c2, c1, c0};
      return j;
   endfunction

   // Capital-form table over the 32 letter positions. The lower-case half
   // differs only in the first letter, which the caller adjusts.
   function automatic job_type letter_job(input logic [4:0] idx);
      job_type j;
      unique case (idx)
         5'd0:  j = mk_job(3'd1, "A", 8'h00, 8'h00, 8'h00);
         5'd1:  j = mk_job(3'd1, "B", 8'h00, 8'h00, 8'h00);
         5'd2:  j = mk_job(3'd1, "V", 8'h00, 8'h00, 8'h00);
         5'd3:  j = mk_job(3'd1, "G", 8'h00, 8'h00, 8'h00);
         5'd4:  j = mk_job(3'd1, "D", 8'h00, 8'h00, 8'h00);
         5'd5:  j = mk_job(3'd1, "E", 8'h00, 8'h00, 8'h00);
         5'd6:  j = mk_job(3'd2, "Z", "h", 8'h00, 8'h00);
         5'd7:  j = mk_job(3'd1, "Z", 8'h00, 8'h00, 8'h00);
         5'd8:  j = mk_job(3'd1, "I", 8'h00, 8'h00, 8'h00);
         5'd9:  j = mk_job(3'd1, "Y", 8'h00, 8'h00, 8'h00);
         5'd10: j = mk_job(3'd1, "K", 8'h00, 8'h00, 8'h00);
         5'd11: j = mk_job(3'd1, "L", 8'h00, 8'h00, 8'h00);
         5'd12: j = mk_job(3'd1, "M", 8'h00, 8'h00, 8'h00);
         5'd13: j = mk_job(3'd1, "N", 8'h00, 8'h00, 8'h00);
         5'd14: j = mk_job(3'd1, "O", 8'h00, 8'h00, 8'h00);
         5'd15: j = mk_job(3'd1, "P", 8'h00, 8'h00, 8'h00);
         5'd16: j = mk_job(3'd1, "R", 8'h00, 8'h00, 8'h00);
         5'd17: j = mk_job(3'd1, "S", 8'h00, 8'h00, 8'h00);
         5'd18: j = mk_job(3'd1, "T", 8'h00, 8'h00, 8'h00);
         5'd19: j = mk_job(3'd1, "U", 8'h00, 8'h00, 8'h00);
         5'd20: j = mk_job(3'd1, "F", 8'h00, 8'h00, 8'h00);
         5'd21: j = mk_job(3'd2, "K", "h", 8'h00, 8'h00);
         5'd22: j = mk_job(3'd2, "T", "s", 8'h00, 8'h00);
         5'd23: j = mk_job(3'd2, "C", "h", 8'h00, 8'h00);
         5'd24: j = mk_job(3'd2, "S", "h", 8'h00, 8'h00);
         5'd25: j = mk_job(3'd4, "S", "h", "c", "h");
         5'd26: j = mk_job(3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
         5'd27: j = mk_job(3'd1, "Y", 8'h00, 8'h00, 8'h00);
         5'd28: j = mk_job(3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
         5'd29: j = mk_job(3'd1, "E", 8'h00, 8'h00, 8'h00);
         5'd30: j = mk_job(3'd2, "Y", "u", 8'h00, 8'h00);
         5'd31: j = mk_job(3'd2, "Y", "a", 8'h00, 8'h00);
         default: j = mk_job(3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      endcase
      return j;
   endfunction

   // Maps an 11-bit code point to the characters it becomes.
   function automatic job_type map_code(input logic [10:0] code);
      job_type     j;
      logic [10:0] offset;
      offset = code - CODE_TABLE_BASE;
      if (code == CODE_YO_UPPER) begin
         j = mk_job(3'd1, "E", 8'h00, 8'h00, 8'h00);
      end else if (code == CODE_YO_LOWER) begin
         j = mk_job(3'd1, "e", 8'h00, 8'h00, 8'h00);
      end else if (code >= CODE_TABLE_BASE && code < CODE_TABLE_END) begin
         j = letter_job(offset[4:0]);
         if (offset[5]) begin
            j.chars[0] = j.chars[0] | CASE_BIT;
         end
      end else begin
         j = mk_job(3'd1, CHAR_UNKNOWN, 8'h00, 8'h00, 8'h00);
      end
      return j;
   endfunction

endpackage

// File: design/ucyr_front.sv
// Front part of the transliterator: accepts input bytes, tracks a held two-byte
// lead and pushes a job for each plain byte or pair that yields characters.
// Depends on ucyr_pkg.
module ucyr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_byte_value,
   input  logic              req_end_of_text,
   output logic              push_valid,
   output ucyr_pkg::job_type push_job,
   input  logic              queue_full
);
   import ucyr_pkg::*;

   logic       lead_pending_ff, lead_pending_in;
   logic [4:0] lead_bits_ff,    lead_bits_in;
   logic       accept;
   logic       is_lead;
   job_type    pair_job;

   // A transaction is taken only while the queue has room for its job.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_lead   = (req_byte_value & LEAD_MASK) == LEAD_PATTERN;
   assign pair_job  = map_code({lead_bits_ff, req_byte_value[5:0]});

   // Classify the byte: partner of a held lead, new lead, or plain byte.
   always_comb begin
      lead_pending_in = lead_pending_ff;
      lead_bits_in    = lead_bits_ff;
      push_valid      = 1'b0;
      push_job        = mk_job(3'd1, req_byte_value, 8'h00, 8'h00, 8'h00);
      if (accept) begin
         priority if (lead_pending_ff) begin
            lead_pending_in = 1'b0;
            lead_bits_in    = 5'd0;
            push_job        = pair_job;
            push_valid      = pair_job.count != '0;
         end else if (is_lead && !req_end_of_text) begin
            lead_pending_in = 1'b1;
            lead_bits_in    = req_byte_value[4:0];
         end else begin
            push_valid      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_bits_ff    <= 5'd0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_bits_ff    <= lead_bits_in;
      end
   end

   // With no lead held, the saved lead bits stay cleared.
   assert property (@(posedge clock) disable iff (reset)
      !lead_pending_ff |-> (lead_bits_ff == 5'd0))
      else $error("lead bits set while no lead is held");

   // A lead is never held across a push of its own byte.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !lead_pending_ff && is_lead && !req_end_of_text) |-> !push_valid)
      else $error("lead byte produced a job");

   // Every job pushed carries at least one character.
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_job.count != '0))
      else $error("empty job pushed");

endmodule

// File: design/ucyr_queue.sv
// Short job queue between the front and back parts of the transliterator.
// Depends on ucyr_pkg for the job type and depth.
module ucyr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ucyr_pkg::job_type push_job,
   output logic              full,
   output logic              head_valid,
   output ucyr_pkg::job_type head_job,
   input  logic              pop
);
   import ucyr_pkg::*;

   job_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff,  count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full       = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

// File: design/ucyr_back.sv
// Back part of the transliterator: walks the head job into the result
// register one character a cycle while rsp does not stall. Depends on ucyr_pkg.
module ucyr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  ucyr_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_char_code,
   output logic              rsp_run_last
);
   import ucyr_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            char_ff,      char_in;
   logic                  last_ff,      last_in;
   logic [INDEX_BITS-1:0] idx_ff,       idx_in;
   logic                  load;
   logic                  take;
   logic                  is_last;

   // The result register may be refilled when empty or being taken.
   assign load    = !rsp_valid_ff || !rsp_stall;
   assign take    = load && head_valid;
   assign is_last = (COUNT_BITS'(idx_ff) + 1'b1) == head_job.count;
   assign pop     = take && is_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = head_valid;
      end
      if (take) begin
         char_in = head_job.chars[idx_ff];
         last_in = is_last;
         idx_in  = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_run_last  = last_ff;

   // The character index stays inside the head job.
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (COUNT_BITS'(idx_ff) < head_job.count))
      else $error("character index beyond head job");

   // Between jobs the index is back at the first character.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == '0))
      else $error("index not rewound after job");

   assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("index moved with no job");

endmodule

// File: design/utf8_cyrillic_transliterator_top.sv
// Top level of the UTF-8 Cyrillic to Latin transliterator.
// Depends on ucyr_pkg, ucyr_front, ucyr_queue and ucyr_back.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_byte_value, req_end_of_text
//   rsp      out        rsp_valid/rsp_stall   rsp_char_code, rsp_run_last
//
// A byte is taken every cycle while the job queue has room. A byte that
// gives n results (0 to 4) holds the result register, one character a
// cycle while rsp does not stall, so that register sets the sustained
// rate, lowest for the longest letters. A byte's first result passes the
// job queue, then the result register. Reset clears the held lead, the
// queue and the result valid at the first clock edge with reset high.
// req_stall rises only when the queue is full, which happens when the rsp
// side stalls or when bytes arrive faster than multi-character jobs drain.
module utf8_cyrillic_transliterator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_code,
   output logic       rsp_run_last
);
   import ucyr_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   ucyr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_end_of_text (req_end_of_text),
      .push_valid      (push_valid),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   ucyr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   ucyr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// File: dv/tb.sv
// Testbench for the UTF-8 Cyrillic to Latin transliterator.
// Needs only utf8_cyrillic_transliterator_top and the modules below it.
// A queue-fed driver, a predictor and a checking monitor sit in this one module.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Code points and byte classes of the text stream.
   localparam logic [7:0]  LEAD_MASK     = 8'hE0;
   localparam logic [7:0]  LEAD_MARK     = 8'hC0;
   localparam logic [7:0]  TRAIL_MARK    = 8'h80;
   localparam logic [10:0] CP_RUS_FIRST  = 11'h410;
   localparam logic [10:0] CP_RUS_LAST   = 11'h44F;
   localparam logic [10:0] CP_YO_CAP     = 11'h401;
   localparam logic [10:0] CP_YO_SMALL   = 11'h451;
   localparam logic [10:0] CP_HARD_CAP   = 11'h42A;
   localparam logic [10:0] CP_SOFT_CAP   = 11'h42C;
   localparam logic [10:0] CP_HARD_SMALL = 11'h44A;
   localparam logic [10:0] CP_SOFT_SMALL = 11'h44C;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          RANDOM_BYTES  = 136;

   typedef struct {
      logic [7:0] value;
      logic       eot;
      int         gap;
      bit         drain;
   } text_byte_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } latin_char_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_value  = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_char_code;
   logic       rsp_run_last;

   text_byte_type  text_q[$];
   latin_char_type latin_chars_q[$];
   int             fault_count   = 0;
   int             cycle_count   = 0;
   int             results_seen  = 0;
   int             gap_left      = 0;
   int             stall_left    = 0;

   // Predictor state: the held lead byte.
   logic        lead_held     = 1'b0;
   logic [4:0]  lead_low_bits = 5'd0;

   utf8_cyrillic_transliterator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_code   (rsp_char_code),
      .rsp_run_last    (rsp_run_last)
   );

   always #5 clock = ~clock;

   // Latin spelling of the capital letters, indexed from the first Russian capital.
   function automatic string capital_latin(input logic [4:0] idx);
      case (idx)
         5'd0:  return "A";
         5'd1:  return "B";
         5'd2:  return "V";
         5'd3:  return "G";
         5'd4:  return "D";
         5'd5:  return "E";
         5'd6:  return "Zh";
         5'd7:  return "Z";
         5'd8:  return "I";
         5'd9:  return "Y";
         5'd10: return "K";
         5'd11: return "L";
         5'd12: return "M";
         5'd13: return "N";
         5'd14: return "O";
         5'd15: return "P";
         5'd16: return "R";
         5'd17: return "S";
         5'd18: return "T";
         5'd19: return "U";
         5'd20: return "F";
         5'd21: return "Kh";
         5'd22: return "Ts";
         5'd23: return "Ch";
         5'd24: return "Sh";
         5'd25: return "Shch";
         5'd27: return "Y";
         5'd29: return "E";
         5'd30: return "Yu";
         5'd31: return "Ya";
         default: return "";
      endcase
   endfunction

   // Latin spelling of an 11-bit code point; anything outside Russian is a question mark.
   function automatic string latin_spelling(input logic [10:0] cp);
      logic [10:0] offset;
      string       s;
      offset = cp - CP_RUS_FIRST;
      if (cp == CP_YO_CAP) begin
         s = "E";
      end else if (cp == CP_YO_SMALL) begin
         s = "e";
      end else if (cp >= CP_RUS_FIRST && cp <= CP_RUS_LAST) begin
         s = capital_latin(offset[4:0]);
         if (offset[5]) begin
            s = s.tolower();
         end
      end else begin
         s = "?";
      end
      return s;
   endfunction

   // Works out the characters one accepted byte gives and queues them.
   task automatic transliterate_byte(input logic [7:0] b, input logic eot);
      string          s;
      latin_char_type c;
      if (lead_held) begin
         s = latin_spelling({lead_low_bits, b[5:0]});
         lead_held     = 1'b0;
         lead_low_bits = 5'd0;
         for (int k = 0; k < s.len(); k++) begin
            c.code = s[k];
            c.last = (k == s.len() - 1);
            latin_chars_q.push_back(c);
         end
      end else if ((b & LEAD_MASK) == LEAD_MARK && !eot) begin
         lead_held     = 1'b1;
         lead_low_bits = b[4:0];
      end else begin
         c.code = b;
         c.last = 1'b1;
         latin_chars_q.push_back(c);
      end
   endtask

   task automatic add_byte(input logic [7:0] v, input logic eot, input int gap,
                           input bit drain = 1'b0);
      text_byte_type t;
      t.value = v;
      t.eot   = eot;
      t.gap   = gap;
      t.drain = drain;
      text_q.push_back(t);
   endtask

   task automatic add_pair(input logic [10:0] cp, input logic eot, input int gap);
      add_byte(LEAD_MARK | {3'b000, cp[10:6]}, 1'b0, gap);
      add_byte(TRAIL_MARK | {2'b00, cp[5:0]}, eot, gap);
   endtask

   // Driver: presents queued bytes and predicts each one as it is accepted.
   always @(posedge clock) begin
      bit            presenting;
      text_byte_type t;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         presenting = req_valid;
         if (req_valid && !req_stall) begin
            transliterate_byte(req_byte_value, req_end_of_text);
            presenting = 1'b0;
            gap_left = (text_q.size() > 0) ? text_q[0].gap : 0;
         end
         if (!presenting) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (text_q.size() > 0 &&
                         !(text_q[0].drain && latin_chars_q.size() != 0)) begin
               t = text_q.pop_front();
               req_byte_value  <= t.value;
               req_end_of_text <= t.eot;
               presenting = 1'b1;
            end
         end
         req_valid <= presenting;
      end
   end

   // Monitor: stalls at random and checks every accepted transaction in order.
   always @(posedge clock) begin
      latin_char_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (latin_chars_q.size() == 0) begin
               $error("unexpected transaction: char_code %h run_last %b",
                      rsp_char_code, rsp_run_last);
               fault_count++;
            end else begin
               want = latin_chars_q.pop_front();
               if (rsp_char_code !== want.code) begin
                  $error("char_code: expected %h, got %h", want.code, rsp_char_code);
                  fault_count++;
               end
               if (rsp_run_last !== want.last) begin
                  $error("run_last: expected %b, got %b", want.last, rsp_run_last);
                  fault_count++;
               end
            end
            // Every third stretch of forty transactions runs without stalls.
            stall_left = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      int         n;
      int         gap;
      int         pick;
      logic [10:0] cp;
      logic       eot;

      // Directed bytes: extremes and the awkward sequences.
      add_byte(8'h41, 1'b0, 0);
      add_byte(8'h00, 1'b0, 0);
      add_byte(8'hFF, 1'b1, 2);
      add_byte(8'h7F, 1'b0, 0);
      add_byte(8'h80, 1'b0, 0);          // lone continuation byte passes through
      add_byte(8'hE0, 1'b0, 0);
      add_pair(CP_RUS_FIRST, 1'b0, 0);
      add_pair(CP_RUS_LAST, 1'b0, 0);
      add_pair(CP_RUS_FIRST + 11'd25, 1'b0, 0);   // four-letter capital
      add_pair(CP_RUS_FIRST + 11'd57, 1'b0, 0);   // four-letter small
      add_pair(CP_YO_CAP, 1'b0, 1);
      add_pair(CP_YO_SMALL, 1'b0, 0);
      add_pair(CP_HARD_CAP, 1'b0, 0);
      add_pair(CP_SOFT_SMALL, 1'b0, 3);
      add_pair(11'h0A9, 1'b0, 0);        // code outside the Cyrillic letters
      add_byte(8'hD0, 1'b1, 0);          // lead that ends the text
      add_byte(8'hD0, 1'b0, 0);
      add_byte(8'h41, 1'b0, 0);          // partner without continuation bits
      add_byte(8'hD0, 1'b0, 0);
      add_byte(8'hD0, 1'b0, 0);          // partner that is itself a lead
      add_byte(8'hD1, 1'b0, 0);
      add_byte(8'h81, 1'b1, 0);          // partner that ends the text
      add_byte(8'hC0, 1'b0, 0);
      add_byte(8'h80, 1'b0, 0);
      add_byte(8'hDF, 1'b0, 0);
      add_byte(8'hBF, 1'b1, 0);
      add_byte(8'h20, 1'b0, 4, 1'b1);    // sender holds off until all results are in

      // Random text: mostly well-formed pairs, with ASCII, noise and broken pairs.
      n = 0;
      while (n < RANDOM_BYTES) begin
         gap  = ((n / 20) % 3 == 2) ? 0 : $urandom_range(0, 15);
         eot  = ($urandom_range(0, 7) == 0);
         pick = $urandom_range(0, 19);
         if (n == RANDOM_BYTES / 2) begin
            add_byte(8'h2E, 1'b0, gap, 1'b1);
            n += 1;
         end else if (pick < 10) begin
            cp = 11'h400 + 11'($urandom_range(0, 11'h5F));
            add_pair(cp, eot, gap);
            n += 2;
         end else if (pick < 12) begin
            case ($urandom_range(0, 3))
               0: cp = CP_HARD_CAP;
               1: cp = CP_SOFT_CAP;
               2: cp = CP_HARD_SMALL;
               default: cp = CP_SOFT_SMALL;
            endcase
            add_pair(cp, eot, gap);
            n += 2;
         end else if (pick < 13) begin
            add_pair(11'($urandom_range(0, 2047)), eot, gap);
            n += 2;
         end else if (pick < 14) begin
            add_byte(LEAD_MARK | 8'($urandom_range(0, 31)), 1'b0, gap);
            add_byte(8'($urandom_range(0, 255)), eot, gap);
            n += 2;
         end else if (pick < 17) begin
            add_byte(8'($urandom_range(8'h20, 8'h7E)), eot, gap);
            n += 1;
         end else begin
            add_byte(8'($urandom_range(0, 255)), eot, gap);
            n += 1;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (text_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (latin_chars_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (latin_chars_q.size() != 0) begin
         $error("%0d expected transactions never arrived", latin_chars_q.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
